// ----- src/rbst_pkg.sv -----
// rbst_pkg: shared constants and types of the ray/box slab test
`timescale 1ns / 1ps
`default_nettype none

package rbst_pkg;

    // default number format, signed Q16.16
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_AXES        = 3;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_IVL_LOW  = 3'd6,
        REG_IVL_HIGH = 3'd7
    } reg_idx_t;

    // per-axis side information carried along the divider pipeline
    typedef struct packed {
        logic zero_dir;
        logic miss;
        logic neg_lo;
        logic neg_hi;
    } lane_side_t;

    // per-axis status handed from a lane to the merge logic
    typedef struct packed {
        logic bounded;
        logic miss;
    } lane_flags_t;

endpackage

`default_nettype wire

// ----- src/rbst_div.sv -----
// rbst_div: pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module rbst_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num_in,
    input  wire logic [DEN_W-1:0] den_in,
    output logic      [NUM_W-1:0] quo_out
);

    logic [NUM_W-1:0] num_reg [0:NUM_W];
    logic [NUM_W-1:0] quo_reg [0:NUM_W];
    logic [DEN_W-1:0] rem_reg [0:NUM_W];
    logic [DEN_W-1:0] den_reg [0:NUM_W];

    // load stage
    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= num_in;
            quo_reg[0] <= '0;
            rem_reg[0] <= '0;
            den_reg[0] <= den_in;
        end
    end

    // one trial subtraction per stage
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] quo_next;
        logic [NUM_W-1:0] num_next;

        always_comb begin
            trial    = {rem_reg[k], num_reg[k][NUM_W-1]};
            diff     = trial - {1'b0, den_reg[k]};
            ge       = (trial >= {1'b0, den_reg[k]});
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[k][NUM_W-2:0], ge};
            num_next = num_reg[k] << 1;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k+1] <= num_next;
                quo_reg[k+1] <= quo_next;
                rem_reg[k+1] <= rem_next;
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign quo_out = quo_reg[NUM_W];

endmodule

`default_nettype wire

// ----- src/rbst_lane.sv -----
// rbst_lane: entry and exit t of one axis slab
`timescale 1ns / 1ps
`default_nettype none

module rbst_lane #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [COORD_WIDTH-1:0] org,
    input  wire logic signed [COORD_WIDTH-1:0] dir,
    input  wire logic signed [COORD_WIDTH-1:0] lo,
    input  wire logic signed [COORD_WIDTH-1:0] hi,
    output logic signed      [COORD_WIDTH-1:0] t_enter,
    output logic signed      [COORD_WIDTH-1:0] t_exit,
    output rbst_pkg::lane_flags_t              flags
);
    import rbst_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + FRAC_BITS + 1;
    localparam logic [NW-1:0] LIM_POS = NW'((64'(1) << (W - 1)) - 64'(1));
    localparam logic [NW-1:0] LIM_NEG = NW'(64'(1) << (W - 1));

    logic signed [W:0]   dlo_next, dhi_next;
    logic signed [W:0]   dlo_reg, dhi_reg;
    logic [W-1:0]        dmag_next, dmag_reg;
    lane_side_t          side_next, side_reg;
    lane_side_t          d_reg [0:NW];
    logic [W:0]          mlo, mhi;
    logic [NW-1:0]       q_lo, q_hi;
    logic [W-1:0]        qs_lo, qs_hi;
    logic signed [W-1:0] t1, t2;
    lane_side_t          side_out;
    logic signed [W-1:0] t_enter_next, t_exit_next;
    lane_flags_t         flags_next;
    logic signed [W-1:0] t_enter_reg, t_exit_reg;
    lane_flags_t         flags_reg;

    // differences to the origin, direction magnitude, zero-direction test
    always_comb begin
        dlo_next  = {lo[W-1], lo} - {org[W-1], org};
        dhi_next  = {hi[W-1], hi} - {org[W-1], org};
        dmag_next = dir[W-1] ? W'(-dir) : dir;
        side_next.zero_dir = (dir == '0);
        side_next.miss     = (dir == '0) && ((org < lo) || (org > hi));
        side_next.neg_lo   = dlo_next[W] ^ dir[W-1];
        side_next.neg_hi   = dhi_next[W] ^ dir[W-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dlo_reg  <= dlo_next;
            dhi_reg  <= dhi_next;
            dmag_reg <= dmag_next;
            side_reg <= side_next;
        end
    end

    // numerator magnitudes scaled by the fraction bits
    assign mlo = dlo_reg[W] ? (W+1)'(-dlo_reg) : dlo_reg;
    assign mhi = dhi_reg[W] ? (W+1)'(-dhi_reg) : dhi_reg;

    rbst_div #(.NUM_W(NW), .DEN_W(W)) u_div_lo (
        .aclk    (aclk),
        .en      (en),
        .num_in  (NW'(mlo) << FRAC_BITS),
        .den_in  (dmag_reg),
        .quo_out (q_lo)
    );

    rbst_div #(.NUM_W(NW), .DEN_W(W)) u_div_hi (
        .aclk    (aclk),
        .en      (en),
        .num_in  (NW'(mhi) << FRAC_BITS),
        .den_in  (dmag_reg),
        .quo_out (q_hi)
    );

    // side information follows the divider
    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= side_reg;
            for (int k = 0; k < NW; k++) begin
                d_reg[k+1] <= d_reg[k];
            end
        end
    end

    assign side_out = d_reg[NW];

    // saturate, apply sign, order the pair
    always_comb begin
        if (side_out.neg_lo) begin
            qs_lo = (q_lo > LIM_NEG) ? LIM_NEG[W-1:0] : q_lo[W-1:0];
            t1    = W'(-qs_lo);
        end else begin
            qs_lo = (q_lo > LIM_POS) ? LIM_POS[W-1:0] : q_lo[W-1:0];
            t1    = qs_lo;
        end
        if (side_out.neg_hi) begin
            qs_hi = (q_hi > LIM_NEG) ? LIM_NEG[W-1:0] : q_hi[W-1:0];
            t2    = W'(-qs_hi);
        end else begin
            qs_hi = (q_hi > LIM_POS) ? LIM_POS[W-1:0] : q_hi[W-1:0];
            t2    = qs_hi;
        end
        if (t1 > t2) begin
            t_enter_next = t2;
            t_exit_next  = t1;
        end else begin
            t_enter_next = t1;
            t_exit_next  = t2;
        end
        flags_next.bounded = !side_out.zero_dir;
        flags_next.miss    = side_out.miss;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_enter_reg <= t_enter_next;
            t_exit_reg  <= t_exit_next;
            flags_reg   <= flags_next;
        end
    end

    assign t_enter = t_enter_reg;
    assign t_exit  = t_exit_reg;
    assign flags   = flags_reg;

endmodule

`default_nettype wire

// ----- src/rbst_merge.sv -----
// rbst_merge: narrows the axis intervals and forms the hit flag
`timescale 1ns / 1ps
`default_nettype none

module rbst_merge #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic signed [COORD_WIDTH-1:0] t_enter [rbst_pkg::NUM_AXES],
    input  wire logic signed [COORD_WIDTH-1:0] t_exit  [rbst_pkg::NUM_AXES],
    input  wire rbst_pkg::lane_flags_t         flags   [rbst_pkg::NUM_AXES],
    input  wire logic signed [COORD_WIDTH-1:0] ivl_low,
    input  wire logic signed [COORD_WIDTH-1:0] ivl_high,
    output logic                               hit
);
    import rbst_pkg::*;

    localparam logic signed [COORD_WIDTH-1:0] T_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    logic signed [COORD_WIDTH-1:0] enter, leave;
    logic                          any_bounded, any_miss;

    // latest entry, earliest exit over the bounded axes
    always_comb begin
        enter       = T_MIN;
        leave       = T_MAX;
        any_bounded = 1'b0;
        any_miss    = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            any_miss = any_miss | flags[a].miss;
            if (flags[a].bounded) begin
                any_bounded = 1'b1;
                if (t_enter[a] > enter) enter = t_enter[a];
                if (t_exit[a] < leave)  leave = t_exit[a];
            end
        end
        hit = !any_miss &&
              (!any_bounded || ((enter <= leave) && (enter < ivl_high) && (leave > ivl_low)));
    end

endmodule

`default_nettype wire

// ----- src/ray_box_slab_test_unit.sv -----
// ray_box_slab_test_unit: top level of the ray versus box slab test
//
// Usage: program the ray origin, direction and the accepted t interval
// through the APB port (register i at byte 4*i, 8*i for coordinates over
// 32 bits) while the block is idle. Then stream boxes on the s_ channel,
// one item per cycle; each box yields one item on the m_ channel, the hit
// flag.
// Throughput: one item per cycle while the output is not stalled. The
// three axes run in parallel lanes, each with two pipelined restoring
// dividers that produce one quotient bit per stage.
// Path to the result: lane input registers, divider load, one divider
// stage per numerator bit, lane and top output registers; Q16.16 default.
// Reset: aresetn is synchronous and active low; it empties the pipeline and
// restores origin and direction to zero and the interval to its full range.
// Stall: when m_ready is low with a result waiting, the whole pipeline holds
// and s_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_test_unit #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF,
    localparam int DATA_W     = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB   = (COORD_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_W     = ADDR_LSB + 3
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_W-1:0]             paddr,
    input  wire logic [DATA_W-1:0]             pwdata,
    output logic      [DATA_W-1:0]             prdata,
    output logic                               pready,
    // box items
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_min_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_min_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_min_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_max_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_max_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_box_max_z,
    // result items
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit
);
    import rbst_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int LAT = COORD_WIDTH + FRAC_BITS + 4;

    logic signed [W-1:0] org_reg [NUM_AXES];
    logic signed [W-1:0] dir_reg [NUM_AXES];
    logic signed [W-1:0] ivl_low_reg, ivl_high_reg;
    logic signed [W-1:0] box_lo [NUM_AXES];
    logic signed [W-1:0] box_hi [NUM_AXES];
    logic signed [W-1:0] t_enter [NUM_AXES];
    logic signed [W-1:0] t_exit  [NUM_AXES];
    lane_flags_t         flags   [NUM_AXES];
    logic                cfg_wr;
    reg_idx_t            cfg_idx;
    logic [W-1:0]        rd_val;
    logic                en;
    logic [LAT-1:0]      vld_reg;
    logic                m_valid_reg;
    logic                m_hit_reg;
    logic                hit_next;

    // configuration writes
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                org_reg[a] <= '0;
                dir_reg[a] <= '0;
            end
            ivl_low_reg  <= {1'b1, {(W-1){1'b0}}};
            ivl_high_reg <= {1'b0, {(W-1){1'b1}}};
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ORIGIN_X: org_reg[0]   <= pwdata[W-1:0];
                REG_ORIGIN_Y: org_reg[1]   <= pwdata[W-1:0];
                REG_ORIGIN_Z: org_reg[2]   <= pwdata[W-1:0];
                REG_DIR_X:    dir_reg[0]   <= pwdata[W-1:0];
                REG_DIR_Y:    dir_reg[1]   <= pwdata[W-1:0];
                REG_DIR_Z:    dir_reg[2]   <= pwdata[W-1:0];
                REG_IVL_LOW:  ivl_low_reg  <= pwdata[W-1:0];
                REG_IVL_HIGH: ivl_high_reg <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_ORIGIN_X: rd_val = org_reg[0];
            REG_ORIGIN_Y: rd_val = org_reg[1];
            REG_ORIGIN_Z: rd_val = org_reg[2];
            REG_DIR_X:    rd_val = dir_reg[0];
            REG_DIR_Y:    rd_val = dir_reg[1];
            REG_DIR_Z:    rd_val = dir_reg[2];
            REG_IVL_LOW:  rd_val = ivl_low_reg;
            REG_IVL_HIGH: rd_val = ivl_high_reg;
            default:      rd_val = '0;
        endcase
        prdata = DATA_W'(rd_val);
    end

    // box corners per axis
    assign box_lo[0] = s_box_min_x;
    assign box_lo[1] = s_box_min_y;
    assign box_lo[2] = s_box_min_z;
    assign box_hi[0] = s_box_max_x;
    assign box_hi[1] = s_box_max_y;
    assign box_hi[2] = s_box_max_z;

    // the pipeline advances unless a result waits on a stalled receiver
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        rbst_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk    (aclk),
            .en      (en),
            .org     (org_reg[a]),
            .dir     (dir_reg[a]),
            .lo      (box_lo[a]),
            .hi      (box_hi[a]),
            .t_enter (t_enter[a]),
            .t_exit  (t_exit[a]),
            .flags   (flags[a])
        );
    end

    rbst_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
        .t_enter  (t_enter),
        .t_exit   (t_exit),
        .flags    (flags),
        .ivl_low  (ivl_low_reg),
        .ivl_high (ivl_high_reg),
        .hit      (hit_next)
    );

    // item valid tracking and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LAT-2:0], s_valid};
            m_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg <= hit_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;

endmodule

`default_nettype wire

// ----- src/rbst_checker.sv -----
// rbst_props: port-level checks of the slab test unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rbst_props (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_hit
);

    // a held result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // a held result keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_hit))
        else $error("result changed while stalled");

    // input side stalls exactly when the output is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // a box item that is not taken stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("box item withdrawn before acceptance");

endmodule

bind ray_box_slab_test_unit rbst_props u_rbst_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_hit   (m_hit)
);

`default_nettype wire

// ----- test/rbst_checker.sv -----
// rbst_checker: shadows register writes, predicts hit flags per box and compares
`timescale 1ns / 1ps

module rbst_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic signed [31:0] s_box_min_x,
    input  wire logic signed [31:0] s_box_min_y,
    input  wire logic signed [31:0] s_box_min_z,
    input  wire logic signed [31:0] s_box_max_x,
    input  wire logic signed [31:0] s_box_max_y,
    input  wire logic signed [31:0] s_box_max_z,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic               m_hit,
    output int                      fail_count,
    output int                      pending_hits
);
    import rbst_pkg::*;

    localparam longint T_HI = 64'sd2147483647;
    localparam longint T_LO = -64'sd2147483648;

    // shadow copy of the ray registers
    longint ray_org [3];
    longint ray_dir [3];
    longint ivl_low, ivl_high;

    bit hit_queue [$];

    // exact slab parameter, truncated toward zero and saturated
    function automatic longint slab_param(longint num, longint den);
        bit     neg;
        longint q;
        neg = (num < 0) != (den < 0);
        q = ((num < 0 ? -num : num) <<< 16) / (den < 0 ? -den : den);
        if (neg) begin
            q = -q;
            if (q < T_LO) q = T_LO;
        end else if (q > T_HI) begin
            q = T_HI;
        end
        return q;
    endfunction

    function automatic bit predict_hit(longint lo [3], longint hi [3]);
        bit     hit, bounded;
        longint t_in, t_out, t1, t2, s;
        hit = 1; bounded = 0; t_in = T_LO; t_out = T_HI;
        for (int a = 0; a < 3; a++) begin
            if (ray_dir[a] == 0) begin
                if (ray_org[a] < lo[a] || ray_org[a] > hi[a]) hit = 0;
            end else begin
                t1 = slab_param(lo[a] - ray_org[a], ray_dir[a]);
                t2 = slab_param(hi[a] - ray_org[a], ray_dir[a]);
                if (t1 > t2) begin s = t1; t1 = t2; t2 = s; end
                if (!bounded || t1 > t_in) t_in = t1;
                if (!bounded || t2 < t_out) t_out = t2;
                bounded = 1;
            end
        end
        if (hit && bounded && t_in > t_out) hit = 0;
        if (hit && bounded && !(t_in < ivl_high)) hit = 0;
        if (hit && bounded && !(t_out > ivl_low)) hit = 0;
        return hit;
    endfunction

    always @(posedge aclk) begin
        longint lo [3];
        longint hi [3];
        longint v;
        bit     want;
        if (!aresetn) begin
            foreach (ray_org[a]) begin ray_org[a] = 0; ray_dir[a] = 0; end
            ivl_low = T_LO;
            ivl_high = T_HI;
            hit_queue.delete();
            fail_count = 0;
            pending_hits = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                v = longint'($signed(pwdata));
                case (reg_idx_t'(paddr[4:2]))
                    REG_ORIGIN_X: ray_org[0] = v;
                    REG_ORIGIN_Y: ray_org[1] = v;
                    REG_ORIGIN_Z: ray_org[2] = v;
                    REG_DIR_X:    ray_dir[0] = v;
                    REG_DIR_Y:    ray_dir[1] = v;
                    REG_DIR_Z:    ray_dir[2] = v;
                    REG_IVL_LOW:  ivl_low = v;
                    REG_IVL_HIGH: ivl_high = v;
                endcase
            end
            // compare hit item with the oldest prediction
            if (m_valid && m_ready) begin
                if (hit_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected hit item %0b", m_hit);
                end else begin
                    want = hit_queue.pop_front();
                    if (m_hit !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("hit mismatch: expected %0b actual %0b", want, m_hit);
                    end
                end
            end
            // predict box item
            if (s_valid && s_ready) begin
                lo[0] = s_box_min_x; lo[1] = s_box_min_y; lo[2] = s_box_min_z;
                hi[0] = s_box_max_x; hi[1] = s_box_max_y; hi[2] = s_box_max_z;
                hit_queue.push_back(predict_hit(lo, hi));
            end
            pending_hits = hit_queue.size();
        end
    end
endmodule

// ----- test/tb_ray_box_slab_test_unit.sv -----
// tb_ray_box_slab_test_unit: stimulus and verdict for the ray/box slab test
`timescale 1ns / 1ps

module tb_ray_box_slab_test_unit;
    import rbst_pkg::*;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [4:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    wire  [31:0]        prdata;
    wire                pready;
    logic               s_valid = 0;
    wire                s_ready;
    logic signed [31:0] bmin_x = 0, bmin_y = 0, bmin_z = 0;
    logic signed [31:0] bmax_x = 0, bmax_y = 0, bmax_z = 0;
    wire                m_valid;
    logic               m_ready = 0;
    wire                m_hit;
    int                 fail_count, pending_hits;
    bit                 calm = 0;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    ray_box_slab_test_unit dut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready,
        .s_box_min_x(bmin_x), .s_box_min_y(bmin_y), .s_box_min_z(bmin_z),
        .s_box_max_x(bmax_x), .s_box_max_y(bmax_y), .s_box_max_z(bmax_z),
        .m_valid, .m_ready, .m_hit
    );

    rbst_checker chk (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_valid, .s_ready,
        .s_box_min_x(bmin_x), .s_box_min_y(bmin_y), .s_box_min_z(bmin_z),
        .s_box_max_x(bmax_x), .s_box_max_y(bmax_y), .s_box_max_z(bmax_z),
        .m_valid, .m_ready, .m_hit, .fail_count, .pending_hits
    );

    // receiver stalls in bursts
    always @(posedge aclk) begin
        int stall_left;
        if (!aresetn) begin
            m_ready <= 0;
            stall_left = 0;
        end else if (calm) begin
            m_ready <= 1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, lo, hi);
        write_reg(REG_ORIGIN_X, ox); write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz); write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);    write_reg(REG_DIR_Z, dz);
        write_reg(REG_IVL_LOW, lo);  write_reg(REG_IVL_HIGH, hi);
    endtask

    // drain all hit items before touching the registers
    task automatic wait_idle();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_hits != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // valid stays high between back-to-back items and drops only for a gap
    task automatic send_box(logic [31:0] x0, y0, z0, x1, y1, z1);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        bmin_x <= x0; bmin_y <= y0; bmin_z <= z0;
        bmax_x <= x1; bmax_y <= y1; bmax_z <= z1;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0014_0000) - 32'h000a_0000;
        endcase
    endfunction

    // box near the origin or at random; hits and misses both show up
    task automatic send_rand_box();
        logic [31:0] c [6];
        if ($urandom_range(0, 3) == 0) begin
            foreach (c[i]) c[i] = rand_coord();
        end else begin
            for (int i = 0; i < 3; i++) begin
                c[i] = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                c[i + 3] = c[i] + $urandom_range(0, 32'h0008_0000);
            end
        end
        send_box(c[0], c[1], c[2], c[3], c[4], c[5]);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // reset ray: zero direction, origin test on every axis
        send_box(0, 0, 0, 0, 0, 0);
        send_box(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0);
        send_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        wait_idle();

        // diagonal ray, saturated t on tiny directions, inverted boxes
        set_ray(0, 0, 0, 32'h0001_0000, 32'h0000_0001, 32'hffff_ffff,
                0, 32'h0100_0000);
        send_box(32'h0001_0000, 32'hffff_0000, 32'hffff_0000,
                 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        send_box(32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0001_0000, 32'hffff_0000, 32'hffff_0000);
        send_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_box(32'hfff0_0000, 0, 0, 32'hfff8_0000, 0, 0);
        wait_idle();

        // extreme registers and an empty interval
        set_ray(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 0,
                32'h7fff_ffff, 32'h8000_0000);
        send_box(0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        wait_idle();

        // random rays and boxes
        for (int phase = 0; phase < 8; phase++) begin
            set_ray(rand_coord(), rand_coord(), rand_coord(),
                    ($urandom_range(0, 3) == 0) ? 32'h0 : rand_coord(),
                    ($urandom_range(0, 3) == 0) ? 32'h0 : rand_coord(),
                    ($urandom_range(0, 3) == 0) ? 32'h0 : rand_coord(),
                    (phase % 2) ? 32'h8000_0000 : $urandom_range(0, 32'h0002_0000),
                    (phase % 2) ? 32'h7fff_ffff : $urandom_range(32'h0002_0000, 32'h7fff_ffff));
            if (phase == 7) calm = 1;
            for (int n = 0; n < 50; n++) send_rand_box();
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
